FILE: rtl/core/ddff_pkg.sv
`timescale 1ns / 1ps
package ddff_pkg;

  localparam int MaxOrderDefault = 8;
  // widest index a word can carry, enough for the largest supported order
  localparam int IdxW = 4;

  localparam logic signed [31:0] ONE_Q = 32'sd65536;
  localparam logic signed [63:0] POS_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] NEG_MIN64 = -64'sd2147483648;

  // configuration register indexes
  localparam logic [1:0] REG_STATE_DISCOUNT    = 2'd0;
  localparam logic [1:0] REG_VARIANCE_DISCOUNT = 2'd1;
  localparam logic [1:0] REG_ORDER_IN_USE      = 2'd2;

  typedef enum logic [1:0] {
    KIND_ELEM    = 2'd0,
    KIND_STEP    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [IdxW-1:0]          idx;
    logic signed [31:0]       value;
    logic signed [31:0]       obs;
  } entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > POS_MAX64) r = POS_MAX64[31:0];
    else if (x < NEG_MIN64) r = NEG_MIN64[31:0];
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] satpos(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > POS_MAX64) r = POS_MAX64[31:0];
    else if (x < 64'sd0) r = 32'sd0;
    else r = x[31:0];
    return r;
  endfunction

  // divisor floor at one lsb
  function automatic logic signed [31:0] floor1(input logic signed [31:0] x);
    return (x < 32'sd1) ? 32'sd1 : x;
  endfunction

endpackage

FILE: rtl/core/ddff_front.sv
`timescale 1ns / 1ps
module ddff_front #(
  parameter int MAX_ORDER = ddff_pkg::MaxOrderDefault,
  parameter int PW = $clog2(MAX_ORDER + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic signed [31:0]   regressor_value_i,
  input  logic signed [31:0]   observation_i,
  input  logic [PW-1:0]        order_p_i,
  output logic                 push_o,
  output ddff_pkg::entry_t     entry_o,
  input  logic                 q_full_i
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic [IW-1:0] count_q, count_d;
  logic          completes;
  logic          accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // step completes once the element count reaches the order
  assign completes = (32'(count_q) + 32'd1) >= 32'(order_p_i);

  always_comb begin
    count_d       = count_q;
    entry_o.idx   = ddff_pkg::IdxW'(count_q);
    entry_o.value = regressor_value_i;
    entry_o.obs   = observation_i;
    if (op_i) begin
      entry_o.kind = ddff_pkg::KIND_RESTART;
      count_d      = '0;
    end else if (completes) begin
      entry_o.kind = ddff_pkg::KIND_STEP;
      count_d      = '0;
    end else begin
      entry_o.kind = ddff_pkg::KIND_ELEM;
      count_d      = count_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/core/ddff_queue.sv
`timescale 1ns / 1ps
module ddff_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ddff_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ddff_pkg::entry_t  entry_o
);

  ddff_pkg::entry_t slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

endmodule

FILE: rtl/core/ddff_div.sv
`timescale 1ns / 1ps
module ddff_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  // (num << 16) / den, truncated toward zero, saturated to 32 bits
  localparam int BitsPerCycle = 2;
  localparam int Iters = 64 / BitsPerCycle;

  logic [63:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic        neg_q;
  logic        busy_q;
  logic        done_q;
  logic [$clog2(Iters+1)-1:0] cnt_q;
  logic [47:0] mag;

  assign mag = num_i[47] ? 48'(-num_i) : 48'(num_i);

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int k = 0; k < BitsPerCycle; k++) begin
      rem_d = {rem_d[31:0], dvd_d[63]};
      dvd_d = {dvd_d[62:0], 1'b0};
      if (rem_d >= {1'b0, den_q}) begin
        rem_d    = rem_d - {1'b0, den_q};
        dvd_d[0] = 1'b1;
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      if (dvd_q > 64'h0000_0000_8000_0000) quo_o = ddff_pkg::NEG_MIN64[31:0];
      else quo_o = -$signed(dvd_q[31:0]);
    end else begin
      if (dvd_q > 64'h0000_0000_7FFF_FFFF) quo_o = ddff_pkg::POS_MAX64[31:0];
      else quo_o = $signed(dvd_q[31:0]);
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, 16'b0};
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[47];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ($clog2(Iters+1))'(Iters);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/ddff_back.sv
`timescale 1ns / 1ps
module ddff_back #(
  parameter int MAX_ORDER = ddff_pkg::MaxOrderDefault,
  parameter int PW = $clog2(MAX_ORDER + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ddff_pkg::entry_t   q_entry_i,
  output logic               pop_o,
  input  logic [PW-1:0]      order_p_i,
  input  logic [15:0]        delta_i,
  input  logic [15:0]        beta_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         component_index_o,
  output logic signed [31:0] mean_value_o,
  output logic [30:0]        scale_estimate_o,
  output logic               last_result_o
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int Depth = MAX_ORDER * MAX_ORDER;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [5:0] ST_IDLE    = 6'd0;
  localparam logic [5:0] ST_F_MUL   = 6'd1;
  localparam logic [5:0] ST_F_ACC   = 6'd2;
  localparam logic [5:0] ST_R_RD    = 6'd3;
  localparam logic [5:0] ST_R_DIV   = 6'd4;
  localparam logic [5:0] ST_R_WAIT  = 6'd5;
  localparam logic [5:0] ST_V_RD    = 6'd6;
  localparam logic [5:0] ST_V_MUL   = 6'd7;
  localparam logic [5:0] ST_V_ACC   = 6'd8;
  localparam logic [5:0] ST_Q_MUL   = 6'd9;
  localparam logic [5:0] ST_Q_ACC   = 6'd10;
  localparam logic [5:0] ST_A_DIV   = 6'd11;
  localparam logic [5:0] ST_A_WAIT  = 6'd12;
  localparam logic [5:0] ST_E       = 6'd13;
  localparam logic [5:0] ST_N_MUL   = 6'd14;
  localparam logic [5:0] ST_N_SET   = 6'd15;
  localparam logic [5:0] ST_E2_MUL  = 6'd16;
  localparam logic [5:0] ST_E2_SET  = 6'd17;
  localparam logic [5:0] ST_T_MUL   = 6'd18;
  localparam logic [5:0] ST_T_DIV   = 6'd19;
  localparam logic [5:0] ST_T_WAIT  = 6'd20;
  localparam logic [5:0] ST_D_MUL   = 6'd21;
  localparam logic [5:0] ST_D_SET   = 6'd22;
  localparam logic [5:0] ST_S_DIV   = 6'd23;
  localparam logic [5:0] ST_S_WAIT  = 6'd24;
  localparam logic [5:0] ST_RT_DIV  = 6'd25;
  localparam logic [5:0] ST_RT_WAIT = 6'd26;
  localparam logic [5:0] ST_C_RD    = 6'd27;
  localparam logic [5:0] ST_C_M1    = 6'd28;
  localparam logic [5:0] ST_C_M2    = 6'd29;
  localparam logic [5:0] ST_C_M3    = 6'd30;
  localparam logic [5:0] ST_C_M4    = 6'd31;
  localparam logic [5:0] ST_C_M5    = 6'd32;
  localparam logic [5:0] ST_C_WR    = 6'd33;
  localparam logic [5:0] ST_M_MUL   = 6'd34;
  localparam logic [5:0] ST_M_SET   = 6'd35;
  localparam logic [5:0] ST_EMIT    = 6'd36;

  logic [5:0]  state_q;
  logic [IW-1:0] i_q, j_q;

  // filter state
  logic signed [31:0] mean_q [MAX_ORDER];
  logic signed [31:0] w_q [MAX_ORDER];
  logic signed [31:0] v_q [MAX_ORDER];
  logic signed [31:0] a_q [MAX_ORDER];
  logic signed [31:0] n_q, d_q, s_q;

  // step scratch
  logic signed [55:0] acc_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [47:0] prod_fl;
  logic signed [31:0] obs_q, f_q, qv_q, e_q, e2_q, term_q;
  logic signed [31:0] n_new_q, d_new_q, s_new_q, ratio_q, aa_q, diff_q;
  logic signed [55:0] acc_sum;

  // covariance store, holds R in place between the two sweeps
  logic signed [31:0] cov_mem [Depth];
  logic               vld_q [Depth];
  logic signed [31:0] cov_rd_q;
  logic               vld_rd_q, diag_rd_q;
  logic signed [31:0] cov_data;
  logic [AW-1:0]      addr;
  logic               rd_en, wr_en;
  logic signed [31:0] wr_data;

  logic signed [31:0] mul_a, mul_b;
  logic               div_start, div_done;
  logic signed [47:0] div_num;
  logic signed [31:0] div_den, div_quo;
  logic               i_last, j_last;
  logic signed [31:0] beta_s, delta_fl;
  logic               out_load;

  assign i_last   = (32'(i_q) + 32'd1) >= 32'(order_p_i);
  assign j_last   = (32'(j_q) + 32'd1) >= 32'(order_p_i);
  assign addr     = AW'(AW'(i_q) * AW'(MAX_ORDER) + AW'(j_q));
  assign beta_s   = $signed({16'b0, beta_i});
  assign delta_fl = ddff_pkg::floor1($signed({16'b0, delta_i}));
  assign prod_fl  = prod_q[63:16];
  assign acc_sum  = acc_q + 56'(prod_fl);
  assign cov_data = vld_rd_q ? cov_rd_q : (diag_rd_q ? ddff_pkg::ONE_Q : 32'sd0);
  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_o || !out_stall_i);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state_q)
      ST_F_MUL:  begin mul_a = w_q[i_q];   mul_b = mean_q[i_q]; end
      ST_V_MUL:  begin mul_a = cov_data;   mul_b = w_q[j_q];    end
      ST_Q_MUL:  begin mul_a = w_q[i_q];   mul_b = v_q[i_q];    end
      ST_N_MUL:  begin mul_a = n_q;        mul_b = beta_s;      end
      ST_E2_MUL: begin mul_a = e_q;        mul_b = e_q;         end
      ST_T_MUL:  begin mul_a = s_q;        mul_b = e2_q;        end
      ST_D_MUL:  begin mul_a = beta_s;     mul_b = d_q;         end
      ST_C_M1:   begin mul_a = a_q[i_q];   mul_b = a_q[j_q];    end
      ST_C_M3:   begin mul_a = aa_q;       mul_b = qv_q;        end
      ST_C_M5:   begin mul_a = ratio_q;    mul_b = diff_q;      end
      ST_M_MUL:  begin mul_a = a_q[i_q];   mul_b = e_q;         end
      default:   begin mul_a = 32'sd0;     mul_b = 32'sd0;      end
    endcase
  end

  assign prod_d = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = 48'sd0;
    div_den   = 32'sd1;
    case (state_q)
      ST_R_DIV:  begin div_start = 1'b1; div_num = 48'(cov_data); div_den = delta_fl; end
      ST_A_DIV:  begin div_start = 1'b1; div_num = 48'(v_q[i_q]); div_den = qv_q; end
      ST_T_DIV:  begin div_start = 1'b1; div_num = prod_fl;       div_den = qv_q; end
      ST_S_DIV:  begin
        div_start = 1'b1;
        div_num   = 48'(d_new_q);
        div_den   = ddff_pkg::floor1(n_new_q);
      end
      ST_RT_DIV: begin
        div_start = 1'b1;
        div_num   = 48'(s_new_q);
        div_den   = ddff_pkg::floor1(s_q);
      end
      default:   begin div_start = 1'b0; div_num = 48'sd0; div_den = 32'sd1; end
    endcase
  end

  ddff_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign rd_en   = (state_q == ST_R_RD) || (state_q == ST_V_RD) || (state_q == ST_C_RD);
  assign wr_en   = ((state_q == ST_R_WAIT) && div_done) || (state_q == ST_C_WR);
  assign wr_data = (state_q == ST_C_WR) ? ddff_pkg::sat32(64'(prod_fl)) : div_quo;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cov_mem[addr] <= wr_data;
    end
    if (rd_en) begin
      cov_rd_q  <= cov_mem[addr];
      vld_rd_q  <= vld_q[addr];
      diag_rd_q <= (i_q == j_q);
    end
  end

  // entries never written since reset or restart read as identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) vld_q[k] <= 1'b0;
    end else if (pop_o && (q_entry_i.kind == ddff_pkg::KIND_RESTART)) begin
      for (int k = 0; k < Depth; k++) vld_q[k] <= 1'b0;
    end else if (wr_en) begin
      vld_q[addr] <= 1'b1;
    end
  end

  // regressor row, no reset
  always_ff @(posedge clk_i) begin
    if (pop_o && (q_entry_i.kind != ddff_pkg::KIND_RESTART)) begin
      w_q[q_entry_i.idx[IW-1:0]] <= q_entry_i.value;
    end
  end

  // step scratch, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:   begin obs_q <= q_entry_i.obs; acc_q <= '0; end
      ST_F_ACC:  begin
        // forecast done, clear the sum for the first row of R W
        if (i_last) begin
          f_q   <= ddff_pkg::sat32(64'(acc_sum));
          acc_q <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      ST_V_ACC:  begin
        if (j_last) begin
          v_q[i_q] <= ddff_pkg::sat32(64'(acc_sum));
          if (i_last) acc_q <= 56'(s_q);
          else acc_q <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      ST_Q_ACC:  begin
        acc_q <= acc_sum;
        if (i_last) qv_q <= ddff_pkg::floor1(ddff_pkg::sat32(64'(acc_sum)));
      end
      ST_A_WAIT: if (div_done) a_q[i_q] <= div_quo;
      ST_E:      e_q <= ddff_pkg::sat32(64'(obs_q) - 64'(f_q));
      ST_N_SET:  n_new_q <= ddff_pkg::satpos(64'(prod_fl) + 64'(ddff_pkg::ONE_Q));
      ST_E2_SET: e2_q <= ddff_pkg::satpos(64'(prod_fl));
      ST_T_WAIT: if (div_done) term_q <= div_quo;
      ST_D_SET:  d_new_q <= ddff_pkg::satpos(64'(prod_fl) + 64'(term_q));
      ST_S_WAIT: if (div_done) s_new_q <= div_quo;
      ST_RT_WAIT: if (div_done) ratio_q <= div_quo;
      ST_C_M2:   aa_q <= ddff_pkg::sat32(64'(prod_fl));
      ST_C_M4:   diff_q <= ddff_pkg::sat32(64'(cov_data) - 64'(prod_fl));
      default:   acc_q <= acc_q;
    endcase
  end

  // sequencer and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= ddff_pkg::ONE_Q;
      d_q     <= ddff_pkg::ONE_Q;
      s_q     <= ddff_pkg::ONE_Q;
      for (int k = 0; k < MAX_ORDER; k++) mean_q[k] <= 32'sd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          if (pop_o) begin
            if (q_entry_i.kind == ddff_pkg::KIND_RESTART) begin
              n_q <= ddff_pkg::ONE_Q;
              d_q <= ddff_pkg::ONE_Q;
              s_q <= ddff_pkg::ONE_Q;
              for (int k = 0; k < MAX_ORDER; k++) mean_q[k] <= 32'sd0;
            end else if (q_entry_i.kind == ddff_pkg::KIND_STEP) begin
              state_q <= ST_F_MUL;
            end
          end
        end
        ST_F_MUL: state_q <= ST_F_ACC;
        ST_F_ACC: begin
          if (i_last) begin
            i_q <= '0;
            state_q <= ST_R_RD;
          end else begin
            i_q <= i_q + 1'b1;
            state_q <= ST_F_MUL;
          end
        end
        ST_R_RD:  state_q <= ST_R_DIV;
        ST_R_DIV: state_q <= ST_R_WAIT;
        ST_R_WAIT: begin
          if (div_done) begin
            if (j_last) begin
              j_q <= '0;
              if (i_last) begin
                i_q <= '0;
                state_q <= ST_V_RD;
              end else begin
                i_q <= i_q + 1'b1;
                state_q <= ST_R_RD;
              end
            end else begin
              j_q <= j_q + 1'b1;
              state_q <= ST_R_RD;
            end
          end
        end
        ST_V_RD:  state_q <= ST_V_MUL;
        ST_V_MUL: state_q <= ST_V_ACC;
        ST_V_ACC: begin
          if (j_last) begin
            j_q <= '0;
            if (i_last) begin
              i_q <= '0;
              state_q <= ST_Q_MUL;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= ST_V_RD;
            end
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= ST_V_RD;
          end
        end
        ST_Q_MUL: state_q <= ST_Q_ACC;
        ST_Q_ACC: begin
          if (i_last) begin
            i_q <= '0;
            state_q <= ST_A_DIV;
          end else begin
            i_q <= i_q + 1'b1;
            state_q <= ST_Q_MUL;
          end
        end
        ST_A_DIV: state_q <= ST_A_WAIT;
        ST_A_WAIT: begin
          if (div_done) begin
            if (i_last) begin
              i_q <= '0;
              state_q <= ST_E;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= ST_A_DIV;
            end
          end
        end
        ST_E:       state_q <= ST_N_MUL;
        ST_N_MUL:   state_q <= ST_N_SET;
        ST_N_SET:   state_q <= ST_E2_MUL;
        ST_E2_MUL:  state_q <= ST_E2_SET;
        ST_E2_SET:  state_q <= ST_T_MUL;
        ST_T_MUL:   state_q <= ST_T_DIV;
        ST_T_DIV:   state_q <= ST_T_WAIT;
        ST_T_WAIT:  if (div_done) state_q <= ST_D_MUL;
        ST_D_MUL:   state_q <= ST_D_SET;
        ST_D_SET:   state_q <= ST_S_DIV;
        ST_S_DIV:   state_q <= ST_S_WAIT;
        ST_S_WAIT:  if (div_done) state_q <= ST_RT_DIV;
        ST_RT_DIV:  state_q <= ST_RT_WAIT;
        ST_RT_WAIT: if (div_done) state_q <= ST_C_RD;
        ST_C_RD:    state_q <= ST_C_M1;
        ST_C_M1:    state_q <= ST_C_M2;
        ST_C_M2:    state_q <= ST_C_M3;
        ST_C_M3:    state_q <= ST_C_M4;
        ST_C_M4:    state_q <= ST_C_M5;
        ST_C_M5:    state_q <= ST_C_WR;
        ST_C_WR: begin
          if (j_last) begin
            j_q <= '0;
            if (i_last) begin
              i_q <= '0;
              state_q <= ST_M_MUL;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= ST_C_RD;
            end
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= ST_C_RD;
          end
        end
        ST_M_MUL: state_q <= ST_M_SET;
        ST_M_SET: begin
          mean_q[i_q] <= ddff_pkg::sat32(64'(mean_q[i_q]) + 64'(prod_fl));
          if (i_last) begin
            i_q <= '0;
            n_q <= n_new_q;
            d_q <= d_new_q;
            s_q <= s_new_q;
            state_q <= ST_EMIT;
          end else begin
            i_q <= i_q + 1'b1;
            state_q <= ST_M_MUL;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (i_last) begin
              i_q <= '0;
              state_q <= ST_IDLE;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      component_index_o <= 3'(i_q);
      mean_value_o      <= mean_q[i_q];
      scale_estimate_o  <= s_q[30:0];
      last_result_o     <= i_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/discount_dlm_forward_filter_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 word
// in        input      in_valid_i / in_stall_o   op, regressor_value, observation
// out       output     out_valid_o / out_stall_i component_index, mean_value,
//                                                scale_estimate, last_result
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a word that does not finish a step, and a restart word, leave the queue without leaving idle
// a finishing word runs P*P + P + 3 quotients for P components on the radix-4 divider,
// with one shared multiplier
// reset and restart load the prior at once: covariance entries read as identity until rewritten
// a two-word queue parts input from the sequencer, input stalls only while the queue is full
// the output register takes a new word as the previous one leaves; out stalls hold the sequencer
module discount_dlm_forward_filter_top #(
  parameter int MAX_ORDER = ddff_pkg::MaxOrderDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [31:0] regressor_value_i,
  input  logic signed [31:0] observation_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         component_index_o,
  output logic signed [31:0] mean_value_o,
  output logic [30:0]        scale_estimate_o,
  output logic               last_result_o
);

  localparam int PW = $clog2(MAX_ORDER + 1);

  logic [15:0]      state_discount_q;
  logic [15:0]      variance_discount_q;
  logic [3:0]       order_in_use_q;
  logic [PW-1:0]    order_p;

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  ddff_pkg::entry_t entry_in, entry_out;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_discount_q    <= 16'd62259;
      variance_discount_q <= 16'd62259;
      order_in_use_q      <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ddff_pkg::REG_STATE_DISCOUNT:    state_discount_q    <= cfg_data_i;
        ddff_pkg::REG_VARIANCE_DISCOUNT: variance_discount_q <= cfg_data_i;
        ddff_pkg::REG_ORDER_IN_USE:      order_in_use_q      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // order zero acts as one, above the build limit acts as the limit
  always_comb begin
    if (order_in_use_q == 4'd0) begin
      order_p = PW'(1);
    end else if (32'(order_in_use_q) > 32'(MAX_ORDER)) begin
      order_p = PW'(MAX_ORDER);
    end else begin
      order_p = PW'(order_in_use_q);
    end
  end

  // front: take words, count elements, tag each word
  ddff_front #(
    .MAX_ORDER (MAX_ORDER),
    .PW        (PW)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .regressor_value_i (regressor_value_i),
    .observation_i     (observation_i),
    .order_p_i         (order_p),
    .push_o            (push),
    .entry_o           (entry_in),
    .q_full_i          (q_full)
  );

  ddff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (entry_out)
  );

  // back: filter update sequencer and result output
  ddff_back #(
    .MAX_ORDER (MAX_ORDER),
    .PW        (PW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_entry_i         (entry_out),
    .pop_o             (pop),
    .order_p_i         (order_p),
    .delta_i           (state_discount_q),
    .beta_i            (variance_discount_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .component_index_o (component_index_o),
    .mean_value_o      (mean_value_o),
    .scale_estimate_o  (scale_estimate_o),
    .last_result_o     (last_result_o)
  );

endmodule

FILE: tb/sv/tb_discount_dlm_forward_filter_top.sv
`timescale 1ns / 1ps
module tb_discount_dlm_forward_filter_top;

  localparam int  Order     = 8;
  localparam int  CycleCap  = 4000000;
  localparam int  SettleCyc = 200;
  localparam logic OP_ELEM    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct {
    logic              op;
    logic signed [31:0] regv;
    logic signed [31:0] obs;
  } in_word_t;

  typedef struct {
    logic [2:0]  comp;
    logic [31:0] mean;
    logic [30:0] scale;
    logic        last;
  } mean_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port, driven by the sequencing block only
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = '0;
  logic [15:0] cfg_data_i = '0;

  // input channel, driven at the falling edge
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic               op_i              = 1'b0;
  logic signed [31:0] regressor_value_i = '0;
  logic signed [31:0] observation_i     = '0;

  // result channel
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         component_index_o;
  logic signed [31:0] mean_value_o;
  logic [30:0]        scale_estimate_o;
  logic               last_result_o;

  discount_dlm_forward_filter_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .regressor_value_i (regressor_value_i),
    .observation_i     (observation_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .component_index_o (component_index_o),
    .mean_value_o      (mean_value_o),
    .scale_estimate_o  (scale_estimate_o),
    .last_result_o     (last_result_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // words waiting to be sent, and mean words the filter still owes us
  in_word_t   send_q[$];
  mean_word_t mean_q[$];

  int  send_idle = 0;
  int  recv_idle = 0;
  int  err_count = 0;
  int  cycles    = 0;
  bit  in_taken  = 1'b0;

  // filter model: configuration and state, discounts and filter values Q16.16 held in longint
  longint delta_cfg;
  longint beta_cfg;
  int     order_cfg;
  longint mean_st[Order];
  longint cov_st[Order*Order];
  longint regbuf[Order];
  int     elem_cnt;
  longint dof_st;
  longint ssum_st;
  longint scale_st;

  function automatic longint clip_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clip_pos(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < 0) return 0;
    return x;
  endfunction

  // product shifted down with floor rounding
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  // quotient truncates toward zero, divisor floored at one lsb
  function automatic longint qdiv(longint num, longint den);
    if (den < 1) den = 1;
    return (num * 65536) / den;
  endfunction

  function automatic void load_prior();
    for (int i = 0; i < Order; i++) begin
      mean_st[i] = 0;
      for (int j = 0; j < Order; j++) cov_st[i*Order+j] = (i == j) ? 65536 : 0;
    end
    elem_cnt = 0;
    dof_st   = 65536;
    ssum_st  = 65536;
    scale_st = 65536;
  endfunction

  // advance the filter by one accepted word and queue the mean words it yields
  function automatic void filter_word(in_word_t w);
    longint     rp[Order*Order];
    longint     v[Order];
    longint     g[Order];
    longint     acc, f, q, e, e2, term, n, d, s, ratio, aa, diff;
    int         p, k;
    mean_word_t m;
    if (w.op == OP_RESTART) begin
      load_prior();
      return;
    end
    p = order_cfg;
    if (p == 0) p = 1;
    if (p > Order) p = Order;
    k = elem_cnt;
    if (k < Order) regbuf[k] = longint'(w.regv);
    k++;
    if (k < p) begin
      elem_cnt = k;
      return;
    end
    elem_cnt = 0;
    // forecast
    acc = 0;
    for (int i = 0; i < p; i++) acc += qmul(regbuf[i], mean_st[i]);
    f = clip_s32(acc);
    // prior covariance and its product with the regressor row
    for (int i = 0; i < p; i++)
      for (int j = 0; j < p; j++)
        rp[i*Order+j] = clip_s32(qdiv(cov_st[i*Order+j], delta_cfg));
    for (int i = 0; i < p; i++) begin
      acc = 0;
      for (int j = 0; j < p; j++) acc += qmul(rp[i*Order+j], regbuf[j]);
      v[i] = clip_s32(acc);
    end
    acc = scale_st;
    for (int i = 0; i < p; i++) acc += qmul(regbuf[i], v[i]);
    q = clip_s32(acc);
    if (q < 1) q = 1;
    for (int i = 0; i < p; i++) g[i] = clip_s32(qdiv(v[i], q));
    e = clip_s32(longint'(w.obs) - f);
    // variance learning
    n     = clip_pos(qmul(dof_st, beta_cfg) + 65536);
    e2    = clip_pos(qmul(e, e));
    term  = qdiv(qmul(scale_st, e2), q);
    d     = clip_pos(qmul(beta_cfg, ssum_st) + term);
    s     = clip_pos(qdiv(d, n));
    ratio = clip_pos(qdiv(s, scale_st));
    for (int i = 0; i < p; i++)
      for (int j = 0; j < p; j++) begin
        aa   = clip_s32(qmul(g[i], g[j]));
        diff = clip_s32(rp[i*Order+j] - qmul(aa, q));
        cov_st[i*Order+j] = clip_s32(qmul(ratio, diff));
      end
    for (int i = 0; i < p; i++) mean_st[i] = clip_s32(mean_st[i] + qmul(g[i], e));
    dof_st   = n;
    ssum_st  = d;
    scale_st = s;
    for (int i = 0; i < p; i++) begin
      m.comp  = 3'(i);
      m.mean  = mean_st[i][31:0];
      m.scale = s[30:0];
      m.last  = (i + 1 == p);
      mean_q.push_back(m);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    err_count++;
  endtask

  // accept side: model the taken word, check the returned mean word
  always @(posedge clk_i) begin : watch
    mean_word_t m;
    in_word_t   w;
    cycles++;
    if (cycles > CycleCap) begin
      $display("status: fail");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w.op   = op_i;
        w.regv = regressor_value_i;
        w.obs  = observation_i;
        filter_word(w);
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (mean_q.size() == 0) begin
          report("unexpected word", {29'd0, component_index_o}, 32'd0);
        end else begin
          m = mean_q.pop_front();
          if (component_index_o !== m.comp)
            report("component_index", {29'd0, component_index_o}, {29'd0, m.comp});
          if (mean_value_o !== m.mean) report("mean_value", mean_value_o, m.mean);
          if (scale_estimate_o !== m.scale)
            report("scale_estimate", {1'b0, scale_estimate_o}, {1'b0, m.scale});
          if (last_result_o !== m.last)
            report("last_result", {31'd0, last_result_o}, {31'd0, m.last});
        end
      end
    end
  end

  // driver: holds a word until taken, gaps and stalls at random
  always @(negedge clk_i) begin : drive
    logic     nv;
    in_word_t w;
    nv = in_valid_i;
    if (in_taken) nv = 1'b0;
    in_taken = 1'b0;
    if (rst_ni && !nv && send_q.size() != 0 && $urandom_range(99) >= send_idle) begin
      w = send_q.pop_front();
      op_i              <= w.op;
      regressor_value_i <= w.regv;
      observation_i     <= w.obs;
      nv = 1'b1;
    end
    in_valid_i  <= nv;
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(32'h6_0000)) - 32'h3_0000;
    endcase
  endfunction

  function automatic void add_word(logic op, logic [31:0] rv, logic [31:0] ob);
    in_word_t w;
    w.op   = op;
    w.regv = rv;
    w.obs  = ob;
    send_q.push_back(w);
  endfunction

  // mostly regressor words with the odd restart
  function automatic void add_random(int count);
    for (int i = 0; i < count; i++)
      add_word(($urandom_range(24) == 0) ? OP_RESTART : OP_ELEM, pick_value(), pick_value());
  endfunction

  task automatic wait_drained();
    while (send_q.size() != 0 || in_valid_i || mean_q.size() != 0) @(posedge clk_i);
    // a restart or a partial step returns nothing, give it time to finish
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ddff_pkg::REG_STATE_DISCOUNT:    delta_cfg = val;
      ddff_pkg::REG_VARIANCE_DISCOUNT: beta_cfg  = val;
      ddff_pkg::REG_ORDER_IN_USE:      order_cfg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(logic [15:0] dl, logic [15:0] bt, logic [15:0] ord);
    wait_drained();
    write_reg(ddff_pkg::REG_STATE_DISCOUNT, dl);
    write_reg(ddff_pkg::REG_VARIANCE_DISCOUNT, bt);
    write_reg(ddff_pkg::REG_ORDER_IN_USE, ord);
  endtask

  initial begin
    delta_cfg = 62259;
    beta_cfg  = 62259;
    order_cfg = 1;
    for (int i = 0; i < Order; i++) regbuf[i] = 0;
    load_prior();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender idles rarely, receiver mostly stalls
    send_idle = 22;
    recv_idle = 79;
    set_filter(16'd62259, 16'd62259, 16'd1);
    // field extremes, both ops, zero and unit values
    add_word(OP_ELEM, 32'h0001_0000, 32'h0001_0000);
    add_word(OP_ELEM, 32'h7fff_ffff, 32'h8000_0000);
    add_word(OP_ELEM, 32'h8000_0000, 32'h7fff_ffff);
    add_word(OP_ELEM, 32'h0000_0000, 32'h0000_0000);
    add_word(OP_ELEM, 32'hffff_0000, 32'h0000_3039);
    add_word(OP_RESTART, 32'hffff_ffff, 32'hffff_ffff);
    add_word(OP_ELEM, 32'h0000_0001, 32'hffff_ffff);
    add_word(OP_ELEM, 32'h7fff_ffff, 32'h7fff_ffff);
    add_word(OP_ELEM, 32'h8000_0000, 32'h8000_0000);
    add_word(OP_ELEM, 32'h5555_5555, 32'haaaa_aaaa);
    add_word(OP_ELEM, 32'haaaa_aaaa, 32'h5555_5555);
    add_word(OP_RESTART, 32'h0, 32'h0);
    add_word(OP_ELEM, 32'h0002_8000, 32'hfffd_0000);
    add_random(14);

    // smallest discounts, three components; a step may be left open
    set_filter(16'd52429, 16'd6554, 16'd3);
    add_random(29);

    // receiver keen, sender sparse; largest discounts and order
    send_idle = 79;
    recv_idle = 22;
    set_filter(16'd65535, 16'd65535, 16'd8);
    add_random(42);

    // order zero behaves as one, a zero state discount hits the divisor floor
    set_filter(16'd0, 16'd0, 16'd0);
    add_random(10);

    // no idling at all; order above the maximum clamps to it
    send_idle = 0;
    recv_idle = 0;
    set_filter(16'd58000, 16'd40000, 16'd15);
    add_random(26);

    set_filter(16'($urandom_range(65535, 52429)), 16'($urandom_range(65535, 6554)), 16'd5);
    add_random(30);

    wait_drained();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
